FILE: hdl/lzrd_pkg.sv
`default_nettype none

package lzrd_pkg;

  // History store geometry
  localparam int unsigned HIST_DEPTH = 8192;
  localparam int unsigned HIST_AW    = $clog2(HIST_DEPTH);

  // Field widths of the token format
  localparam int unsigned CNT_W  = 13;
  localparam int unsigned BYTE_W = 8;

  // Channel operations
  localparam logic OP_OFFER = 1'b0;
  localparam logic OP_PULL  = 1'b1;

  // Header masks
  localparam logic [7:0] EXT_MASK  = 8'hE0;
  localparam logic [7:0] EXT_MATCH = 8'h60;
  localparam logic [CNT_W-1:0] MIN_RUN = CNT_W'(4);

  typedef logic [HIST_AW-1:0] addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;

  typedef enum logic [2:0] {
    PH_HEADER     = 3'd0,
    PH_BACK_LOW   = 3'd1,
    PH_REP_LOW    = 3'd2,
    PH_REP_VALUE  = 3'd3,
    PH_LIT_LOW    = 3'd4,
    PH_LIT_DATA   = 3'd5,
    PH_AFTER_BACK = 3'd6
  } phase_t;

  typedef enum logic [1:0] {
    RUN_NONE   = 2'd0,
    RUN_COPY   = 2'd1,
    RUN_REPEAT = 2'd2
  } run_t;

  typedef enum logic [1:0] {
    KIND_NONE   = 2'd0,
    KIND_DATA   = 2'd1,
    KIND_END    = 2'd2,
    KIND_REFUSE = 2'd3
  } kind_t;

  // Per-item request from the parser to the history/output stage
  typedef struct packed {
    kind_t             kind;
    logic [BYTE_W-1:0] data;     // literal or repeat byte
    logic              is_copy;  // data comes from the history read
    logic              rd_ok;    // history entry has been written before
    addr_t             rd_addr;
    logic              wr;       // decoded byte goes into history
    addr_t             wr_addr;
  } req_t;

  // Advance a history position with wrap
  function automatic addr_t pos_inc(input addr_t p);
    addr_t r;
    if (p == addr_t'(HIST_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + addr_t'(1);
    end
    return r;
  endfunction

  // Step back from a position by an offset, with wrap
  function automatic addr_t pos_sub(input addr_t p, input cnt_t off);
    addr_t o;
    addr_t r;
    o = addr_t'(off);
    if (p >= o) begin
      r = p - o;
    end else begin
      r = addr_t'({1'b0, p} + (HIST_AW + 1)'(HIST_DEPTH) - {1'b0, o});
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/lzrd_if.sv
`default_nettype none

interface lzrd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] in_byte;

  modport source (output valid, output operation, output in_byte, input ready);
  modport sink   (input valid, input operation, input in_byte, output ready);
endinterface

interface lzrd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] out_byte;

  modport source (output valid, output kind, output out_byte, input ready);
  modport sink   (input valid, input kind, input out_byte, output ready);
endinterface

`default_nettype wire

FILE: hdl/lzrd_ram.sv
`default_nettype none

module lzrd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port, registered read port (old data on collision)
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lzrd_parse.sv
`default_nettype none

module lzrd_parse (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           acc,
  input  wire logic           operation,
  input  wire logic [7:0]     in_byte,
  output lzrd_pkg::req_t      req
);

  lzrd_pkg::phase_t phase_r, phase_nxt;
  lzrd_pkg::run_t   run_r, run_nxt;
  lzrd_pkg::addr_t  wr_pos_r, wr_pos_nxt;
  lzrd_pkg::addr_t  copy_pos_r, copy_pos_nxt;
  lzrd_pkg::cnt_t   rem_r, rem_nxt;
  logic [7:0]       rep_r, rep_nxt;
  logic [7:0]       hlat_r, hlat_nxt;
  logic             fin_r, fin_nxt;
  logic             wrapped_r, wrapped_nxt;

  logic             offer_go;
  logic             is_ext;
  logic             hdr_take;
  lzrd_pkg::phase_t hdr_phase;
  lzrd_pkg::cnt_t   lit_cnt;
  lzrd_pkg::cnt_t   rep_cnt;
  lzrd_pkg::cnt_t   back_len;
  lzrd_pkg::cnt_t   offset;

  // Decode helpers
  assign offer_go = acc && !fin_r && (operation == lzrd_pkg::OP_OFFER)
                    && (run_r == lzrd_pkg::RUN_NONE);
  assign is_ext   = (in_byte & lzrd_pkg::EXT_MASK) == lzrd_pkg::EXT_MATCH;
  assign lit_cnt  = {hlat_r[4:0], in_byte};
  assign rep_cnt  = lzrd_pkg::cnt_t'({hlat_r[3:0], in_byte}) + lzrd_pkg::MIN_RUN;
  assign back_len = lzrd_pkg::cnt_t'(hlat_r[6:5]) + lzrd_pkg::MIN_RUN;
  assign offset   = {hlat_r[4:0], in_byte};

  // Phase that a header byte leads to
  always_comb begin
    if (in_byte[7]) begin
      hdr_phase = lzrd_pkg::PH_BACK_LOW;
    end else if (in_byte[6]) begin
      hdr_phase = in_byte[4] ? lzrd_pkg::PH_REP_LOW : lzrd_pkg::PH_REP_VALUE;
    end else if (in_byte[5]) begin
      hdr_phase = lzrd_pkg::PH_LIT_LOW;
    end else if (in_byte[4:0] != 5'd0) begin
      hdr_phase = lzrd_pkg::PH_LIT_DATA;
    end else begin
      hdr_phase = lzrd_pkg::PH_HEADER;
    end
  end

  // Next parse phase
  always_comb begin
    phase_nxt = phase_r;
    if (offer_go) begin
      case (phase_r)
        lzrd_pkg::PH_BACK_LOW:  phase_nxt = lzrd_pkg::PH_AFTER_BACK;
        lzrd_pkg::PH_REP_LOW:   phase_nxt = lzrd_pkg::PH_REP_VALUE;
        lzrd_pkg::PH_REP_VALUE: phase_nxt = lzrd_pkg::PH_HEADER;
        lzrd_pkg::PH_LIT_LOW: begin
          phase_nxt = (lit_cnt != '0) ? lzrd_pkg::PH_LIT_DATA : lzrd_pkg::PH_HEADER;
        end
        lzrd_pkg::PH_LIT_DATA: begin
          if (rem_r <= lzrd_pkg::cnt_t'(1)) begin
            phase_nxt = lzrd_pkg::PH_HEADER;
          end
        end
        lzrd_pkg::PH_AFTER_BACK: begin
          if (!is_ext) begin
            phase_nxt = hdr_phase;
          end
        end
        default: phase_nxt = hdr_phase;
      endcase
    end
  end

  // Run state, positions and the request for this item
  always_comb begin
    run_nxt      = run_r;
    wr_pos_nxt   = wr_pos_r;
    copy_pos_nxt = copy_pos_r;
    rem_nxt      = rem_r;
    rep_nxt      = rep_r;
    hlat_nxt     = hlat_r;
    fin_nxt      = fin_r;
    wrapped_nxt  = wrapped_r;
    hdr_take     = 1'b0;

    req.kind    = lzrd_pkg::KIND_NONE;
    req.data    = '0;
    req.is_copy = 1'b0;
    req.rd_addr = copy_pos_r;
    req.rd_ok   = wrapped_r || (copy_pos_r < wr_pos_r);
    req.wr      = 1'b0;
    req.wr_addr = wr_pos_r;

    if (fin_r) begin
      req.kind = lzrd_pkg::KIND_END;
    end else if (operation == lzrd_pkg::OP_PULL) begin
      if (run_r == lzrd_pkg::RUN_NONE || rem_r == '0) begin
        req.kind = lzrd_pkg::KIND_REFUSE;
      end else begin
        req.kind = lzrd_pkg::KIND_DATA;
        req.wr   = 1'b1;
        if (run_r == lzrd_pkg::RUN_COPY) begin
          req.is_copy  = 1'b1;
          copy_pos_nxt = lzrd_pkg::pos_inc(copy_pos_r);
        end else begin
          req.data = rep_r;
        end
        rem_nxt = rem_r - lzrd_pkg::cnt_t'(1);
        if (rem_r == lzrd_pkg::cnt_t'(1)) begin
          run_nxt = lzrd_pkg::RUN_NONE;
        end
      end
    end else if (run_r != lzrd_pkg::RUN_NONE) begin
      req.kind = lzrd_pkg::KIND_REFUSE;
    end else begin
      case (phase_r)
        lzrd_pkg::PH_BACK_LOW: begin
          copy_pos_nxt = lzrd_pkg::pos_sub(wr_pos_r, offset);
          rem_nxt      = back_len;
          run_nxt      = lzrd_pkg::RUN_COPY;
        end
        lzrd_pkg::PH_REP_LOW: rem_nxt = rep_cnt;
        lzrd_pkg::PH_REP_VALUE: begin
          rep_nxt = in_byte;
          run_nxt = lzrd_pkg::RUN_REPEAT;
        end
        lzrd_pkg::PH_LIT_LOW: rem_nxt = lit_cnt;
        lzrd_pkg::PH_LIT_DATA: begin
          req.kind = lzrd_pkg::KIND_DATA;
          req.data = in_byte;
          req.wr   = 1'b1;
          if (rem_r != '0) begin
            rem_nxt = rem_r - lzrd_pkg::cnt_t'(1);
          end
        end
        lzrd_pkg::PH_AFTER_BACK: begin
          if (is_ext) begin
            rem_nxt = lzrd_pkg::cnt_t'(in_byte[4:0]);
            if (in_byte[4:0] != 5'd0) begin
              run_nxt = lzrd_pkg::RUN_COPY;
            end
          end else begin
            hdr_take = 1'b1;
          end
        end
        default: hdr_take = 1'b1;
      endcase

      // Latch a new header
      if (hdr_take) begin
        hlat_nxt = in_byte;
        if (in_byte == 8'd0) begin
          fin_nxt  = 1'b1;
          req.kind = lzrd_pkg::KIND_END;
        end else if (!in_byte[7] && in_byte[6] && !in_byte[4]) begin
          rem_nxt = lzrd_pkg::cnt_t'(in_byte[3:0]) + lzrd_pkg::MIN_RUN;
        end else if (!in_byte[7] && !in_byte[6] && !in_byte[5]) begin
          rem_nxt = lzrd_pkg::cnt_t'(in_byte[4:0]);
        end
      end
    end

    // Advance the write position and track the fill of the history
    if (req.wr) begin
      wr_pos_nxt = lzrd_pkg::pos_inc(wr_pos_r);
      if (wr_pos_r == lzrd_pkg::addr_t'(lzrd_pkg::HIST_DEPTH - 1)) begin
        wrapped_nxt = 1'b1;
      end
    end
  end

  // Control registers, updated on each accepted item
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= lzrd_pkg::PH_HEADER;
      run_r      <= lzrd_pkg::RUN_NONE;
      wr_pos_r   <= '0;
      copy_pos_r <= '0;
      rem_r      <= '0;
      rep_r      <= '0;
      hlat_r     <= '0;
      fin_r      <= 1'b0;
      wrapped_r  <= 1'b0;
    end else if (acc) begin
      phase_r    <= phase_nxt;
      run_r      <= run_nxt;
      wr_pos_r   <= wr_pos_nxt;
      copy_pos_r <= copy_pos_nxt;
      rem_r      <= rem_nxt;
      rep_r      <= rep_nxt;
      hlat_r     <= hlat_nxt;
      fin_r      <= fin_nxt;
      wrapped_r  <= wrapped_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/lzrd_out.sv
`default_nettype none

module lzrd_out (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   acc,
  input  wire lzrd_pkg::req_t         req,
  output logic                        free,
  input  wire logic [7:0]             ram_q,
  output logic                        ram_we,
  output lzrd_pkg::addr_t             ram_waddr,
  output logic [7:0]                  ram_wdata,
  output logic                        ram_re,
  lzrd_out_if.source                  out_ch
);

  lzrd_pkg::req_t s1_r;
  logic           s1_v_r;
  logic           fwd_r;
  logic [7:0]     fwd_data_r;
  logic           out_v_r;
  logic [1:0]     out_kind_r;
  logic [7:0]     out_byte_r;

  logic           out_free;
  logic           s1_adv;
  logic [7:0]     res;

  // Handshake between the stages
  assign out_free = !out_v_r || out_ch.ready;
  assign s1_adv   = s1_v_r && out_free;
  assign free     = !s1_v_r || s1_adv;

  // Resolve the byte of the item in the history stage
  always_comb begin
    if (!s1_r.is_copy) begin
      res = s1_r.data;
    end else if (fwd_r) begin
      res = fwd_data_r;
    end else if (s1_r.rd_ok) begin
      res = ram_q;
    end else begin
      res = '0;
    end
  end

  // History access: read on a copy pull, write when the item moves on
  assign ram_re    = acc && req.is_copy;
  assign ram_we    = s1_adv && s1_r.wr;
  assign ram_waddr = s1_r.wr_addr;
  assign ram_wdata = res;

  // Hold the stage payload; catch a read of the entry being written now
  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r       <= req;
      fwd_r      <= ram_we && (s1_r.wr_addr == req.rd_addr);
      fwd_data_r <= res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (free) begin
      s1_v_r <= acc;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (out_free) begin
      out_v_r <= s1_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_kind_r <= s1_r.kind;
      out_byte_r <= (s1_r.kind == lzrd_pkg::KIND_DATA) ? res : 8'd0;
    end
  end

  assign out_ch.valid    = out_v_r;
  assign out_ch.kind     = out_kind_r;
  assign out_ch.out_byte = out_byte_r;

endmodule

`default_nettype wire

FILE: hdl/lz_rle_byte_decompressor.sv
// Streaming decoder for a byte-wise LZ/RLE token format with an 8192-byte
// history.
// in_ch carries one item per handshake: operation 0 offers a compressed byte,
// operation 1 pulls the next byte of a pending copy or repeat run.
// out_ch returns exactly one item for each accepted input item: kind
// (none, data, end of stream, refused) and out_byte, zero unless kind is data.
// Pipeline: the parser issues the history read as the item is accepted; the
// history stage then writes the history and loads the output register.
// Throughput: one item per cycle while out_ch is ready; the history memory
// takes one read and one write per cycle, and a read of the entry being
// written in the same cycle is forwarded.
// Reset: synchronous, active low; clears the parser state and both stages.
// The history memory is not swept: a write pointer and a wrap flag mark
// which entries hold data, and unwritten entries read as zero, so the block
// takes items as soon as reset is released.
// Stall: when out_ch is not ready, the result stays in the output register;
// one more item may enter the history stage, then in_ch.ready drops until
// the output drains.
`default_nettype none

module lz_rle_byte_decompressor (
  input  wire logic   clk,
  input  wire logic   rst_n,
  lzrd_in_if.sink     in_ch,
  lzrd_out_if.source  out_ch
);

  logic            acc;
  logic            free;
  lzrd_pkg::req_t  req;
  logic [7:0]      ram_q;
  logic            ram_we;
  lzrd_pkg::addr_t ram_waddr;
  logic [7:0]      ram_wdata;
  logic            ram_re;

  assign in_ch.ready = free;
  assign acc         = in_ch.valid && free;

  lzrd_parse u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .operation (in_ch.operation),
    .in_byte   (in_ch.in_byte),
    .req       (req)
  );

  lzrd_out u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (acc),
    .req       (req),
    .free      (free),
    .ram_q     (ram_q),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .out_ch    (out_ch)
  );

  lzrd_ram #(
    .WIDTH (lzrd_pkg::BYTE_W),
    .DEPTH (lzrd_pkg::HIST_DEPTH)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (req.rd_addr),
    .rdata (ram_q)
  );

endmodule

`default_nettype wire
